// ===== design/vt_pkg.sv =====
// ----------------------------------------------------------------------------
// vt_pkg: shared types and constants of the vertex transform
// Fixed-point widths, vertex kind codes, matrix reset image and the
// stage-enable bundle that the top level hands to the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package vt_pkg;

    // Q16.16 component and arithmetic widths.
    localparam int VT_DATA_W = 32;
    localparam int VT_FRAC_W = 16;
    localparam int VT_PROD_W = 2 * VT_DATA_W;
    localparam int VT_SUM_W  = VT_PROD_W + 2;
    localparam int VT_LANES  = 4;

    // Configuration register file.
    localparam int VT_NUM_REGS  = 8;
    localparam int VT_REG_W     = 64;
    localparam int VT_CFG_IDX_W = 4;
    localparam int VT_REG_IDX_W = $clog2(VT_NUM_REGS);

    // Vertex kind codes; any other code behaves as a four-component vector.
    localparam logic [1:0] VT_OP_2D = 2'd0;
    localparam logic [1:0] VT_OP_3D = 2'd1;
    localparam logic [1:0] VT_OP_4D = 2'd2;

    typedef logic signed [VT_DATA_W-1:0] vt_data_t;
    typedef logic signed [VT_PROD_W-1:0] vt_prod_t;
    typedef logic signed [VT_SUM_W-1:0]  vt_sum_t;
    typedef logic [VT_REG_W-1:0]         vt_reg_t;
    typedef vt_data_t                    vt_vec_t [VT_LANES];

    localparam vt_data_t VT_ONE_Q16  = 32'sh0001_0000;
    localparam vt_data_t VT_ZERO_Q16 = 32'sh0000_0000;
    localparam vt_data_t VT_MAX_Q16  = 32'sh7FFF_FFFF;
    localparam vt_data_t VT_MIN_Q16  = 32'sh8000_0000;

    // Reset image of the register file: the identity matrix.
    localparam vt_reg_t VT_MAT_RESET [VT_NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // Load enables of the lane pipeline stages.
    typedef struct packed {
        logic mul;
        logic add;
        logic sat;
    } vt_stage_en_t;

    typedef struct packed {
        vt_data_t out_x;
        vt_data_t out_y;
        vt_data_t out_z;
        vt_data_t out_w;
        logic     saturated;
    } vt_result_t;

    // Lanes whose results are reported for a given vertex kind.
    function automatic logic [VT_LANES-1:0] vt_lane_mask(input logic [1:0] op);
        logic [VT_LANES-1:0] mask;
        case (op)
            VT_OP_2D: mask = 4'b0011;
            VT_OP_3D: mask = 4'b0111;
            default:  mask = 4'b1111;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== design/vt_vertex_if.sv =====
// ----------------------------------------------------------------------------
// vt_vertex_if: input vertex channel
// Valid/ready channel carrying the vertex kind and four Q16.16 components.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt_vertex_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;

    modport source (output valid, op, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, op, in_x, in_y, in_z, in_w, output ready);
endinterface

`default_nettype wire

// ===== design/vt_result_if.sv =====
// ----------------------------------------------------------------------------
// vt_result_if: transformed vertex channel
// Valid/ready channel carrying four Q16.16 components and a clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;

    modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

`default_nettype wire

// ===== design/vt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// vt_cfg_if: register write channel
// Valid/ready channel carrying a register index and 64-bit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/vertex_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4: Q16.16 homogeneous vertex (row vector) times 4x4 matrix
// Throughput: one vertex transaction per cycle, sustained with a ready sink.
// Stages: the input register, the multipliers, the adder and the saturation
//   stage, and the output register is the fifth stage.
// Reset: rst_n clears every stage valid bit and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_4x4
    import vt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vt_vertex_if.sink   vtx,
    vt_result_if.source res,
    vt_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Matrix register file. Register 2r holds columns 0 and 1 of row r,
    // register 2r+1 holds columns 2 and 3; the even column sits in the
    // low half. Writes past the last register are dropped. The port never
    // stalls; the user must write only with the pipeline empty (not enforced).
    // ------------------------------------------------------------------
    vt_reg_t mat_reg [VT_NUM_REGS];
    logic    cfg_hit;

    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && (cfg.index < VT_CFG_IDX_W'(VT_NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < VT_NUM_REGS; r++)
            begin
                mat_reg[r] <= VT_MAT_RESET[r];
            end
        end
        else if (cfg_hit)
        begin
            mat_reg[cfg.index[VT_REG_IDX_W-1:0]] <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake. Each stage loads when it is empty or when the stage
    // after it moves on, so a stalled sink only stops the stages that are
    // full and bubbles collapse. The input side stays ready while any
    // stage has room, even when a finished result waits at the output.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic en0, en1, en2, en3, en4;
    logic in_take;

    assign en4     = !v4_reg || res.ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign en0     = !v0_reg || en1;
    assign in_take = vtx.valid && en0;

    assign vtx.ready = en0;
    assign res.valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= vtx.valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register. The vertex kind fills in the implied components
    // here: a 2D point gets z = 0 and w = 1.0, a 3D point gets w = 1.0.
    // The kind travels down the pipeline beside the lanes so the output
    // stage knows which components to report.
    // ------------------------------------------------------------------
    vt_data_t   vec_reg [VT_LANES];
    vt_data_t   vec_next [VT_LANES];
    logic [1:0] op0_reg, op1_reg, op2_reg, op3_reg;

    always_comb
    begin
        vec_next[0] = vtx.in_x;
        vec_next[1] = vtx.in_y;
        vec_next[2] = vtx.in_z;
        vec_next[3] = vtx.in_w;
        case (vtx.op)
            VT_OP_2D:
            begin
                vec_next[2] = VT_ZERO_Q16;
                vec_next[3] = VT_ONE_Q16;
            end
            VT_OP_3D:
            begin
                vec_next[3] = VT_ONE_Q16;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            vec_reg <= vec_next;
            op0_reg <= vtx.op;
        end
        if (en1) op1_reg <= op0_reg;
        if (en2) op2_reg <= op1_reg;
        if (en3) op3_reg <= op2_reg;
    end

    // ------------------------------------------------------------------
    // Four lanes side by side, one per output component. Lane i works on
    // column i of the matrix: element M[k][i] for every row k.
    // ------------------------------------------------------------------
    vt_stage_en_t        lane_en;
    vt_data_t            mat_col [VT_LANES][VT_LANES];
    vt_data_t            lane_res [VT_LANES];
    logic [VT_LANES-1:0] lane_sat;

    assign lane_en.mul = en1;
    assign lane_en.add = en2;
    assign lane_en.sat = en3;

    for (genvar i = 0; i < VT_LANES; i++)
    begin : g_lane
        for (genvar k = 0; k < VT_LANES; k++)
        begin : g_elem
            assign mat_col[i][k] = mat_reg[k * 2 + i / 2][(i % 2) * VT_DATA_W +: VT_DATA_W];
        end

        vt_lane u_lane (
            .clk (clk),
            .en  (lane_en),
            .col (mat_col[i]),
            .vtx (vec_reg),
            .res (lane_res[i]),
            .sat (lane_sat[i])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: merges the lane results into one transaction.
    // ------------------------------------------------------------------
    vt_result_t result;

    vt_merge u_merge (
        .clk      (clk),
        .load     (en4),
        .op       (op3_reg),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .result   (result)
    );

    assign res.out_x     = result.out_x;
    assign res.out_y     = result.out_y;
    assign res.out_z     = result.out_z;
    assign res.out_w     = result.out_w;
    assign res.saturated = result.saturated;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // An accepted vertex always lands in the input register.
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> v0_reg)
        else $error("accepted vertex did not enter the input stage");

    // The input side only stalls when every stage holds a vertex.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !vtx.ready |-> (v0_reg && v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while a stage was empty");

    // A clip flag means some component sits at a range limit.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.saturated) |->
            (res.out_x == VT_MAX_Q16 || res.out_x == VT_MIN_Q16 ||
             res.out_y == VT_MAX_Q16 || res.out_y == VT_MIN_Q16 ||
             res.out_z == VT_MAX_Q16 || res.out_z == VT_MIN_Q16 ||
             res.out_w == VT_MAX_Q16 || res.out_w == VT_MIN_Q16))
        else $error("saturated flag without a clipped component");

endmodule

`default_nettype wire

// ===== design/vt_lane.sv =====
// ----------------------------------------------------------------------------
// vt_lane: one output component of the transform
// Four products, an exact sum, then floor by 2^16 and saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_lane
    import vt_pkg::*;
(
    input  wire logic         clk,
    input  wire vt_stage_en_t en,
    input  wire vt_data_t     col [VT_LANES],
    input  wire vt_data_t     vtx [VT_LANES],
    output vt_data_t          res,
    output logic              sat
);

    vt_prod_t prod_reg [VT_LANES];
    vt_sum_t  sum_reg;
    vt_sum_t  sum_next;
    vt_data_t res_reg;
    vt_data_t res_next;
    logic     sat_reg;
    logic     sat_next;

    logic signed [VT_SUM_W-VT_FRAC_W-1:0] floored;
    logic                                 over_hi;
    logic                                 over_lo;

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            for (int k = 0; k < VT_LANES; k++)
            begin
                prod_reg[k] <= VT_PROD_W'(col[k]) * VT_PROD_W'(vtx[k]);
            end
        end
    end

    always_comb
    begin
        sum_next = VT_SUM_W'(prod_reg[0]) + VT_SUM_W'(prod_reg[1])
                 + VT_SUM_W'(prod_reg[2]) + VT_SUM_W'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en.add)
        begin
            sum_reg <= sum_next;
        end
    end

    // Dropping the fraction bits of a two's complement sum floors it.
    assign floored = sum_reg[VT_SUM_W-1:VT_FRAC_W];
    assign over_hi = !floored[$high(floored)] && (|floored[$high(floored)-1:VT_DATA_W-1]);
    assign over_lo = floored[$high(floored)] && !(&floored[$high(floored)-1:VT_DATA_W-1]);

    always_comb
    begin
        sat_next = over_hi || over_lo;
        if (over_hi)
        begin
            res_next = VT_MAX_Q16;
        end
        else if (over_lo)
        begin
            res_next = VT_MIN_Q16;
        end
        else
        begin
            res_next = floored[VT_DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sat)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ===== design/vt_merge.sv =====
// ----------------------------------------------------------------------------
// vt_merge: output register of the transform
// Zeroes the components the vertex kind does not report and folds the clip
// flags of the reported lanes into one.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_merge
    import vt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                load,
    input  wire logic [1:0]          op,
    input  wire vt_data_t            lane_res [VT_LANES],
    input  wire logic [VT_LANES-1:0] lane_sat,
    output vt_result_t               result
);

    vt_result_t          result_reg;
    vt_result_t          result_next;
    logic [VT_LANES-1:0] mask;
    vt_data_t            comp [VT_LANES];

    always_comb
    begin
        mask = vt_lane_mask(op);
        for (int i = 0; i < VT_LANES; i++)
        begin
            comp[i] = mask[i] ? lane_res[i] : VT_ZERO_Q16;
        end
        result_next.out_x     = comp[0];
        result_next.out_y     = comp[1];
        result_next.out_z     = comp[2];
        result_next.out_w     = comp[3];
        result_next.saturated = |(mask & lane_sat);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
